>>> sv/hrp_pkg.sv
// ============================================================================
// hrp_pkg
// Shared types, constants and a helper function for the HTTP request path and
// Host parser.
// ============================================================================
package hrp_pkg;

    // Field buffer limits and widths.
    localparam int MAX_BUF = 4096;
    localparam int LEN_W   = 13;
    localparam int CNT_W   = 12;
    localparam int SUM_W   = CNT_W + 2;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register map.
    localparam int ADDR_W  = 3;
    localparam logic [LEN_W-1:0] BUF_LEN_RESET = LEN_W'(1024);

    // Result status codes.
    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_SMALL = 2'd3;

    // Character constants.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Length of the header name "Host: ".
    localparam logic [2:0] NAME_LEN = 3'd6;

    // One classified request byte, as queued between front and back.
    typedef struct packed {
        logic       restart;
        logic       is_sp;
        logic       is_slash;
        logic       is_cr;
        logic       is_lf;
        logic       is_nul;
        logic [7:0] ch;
    } hrp_item_t;

    // Character of "Host: " at a given match position.
    function automatic logic [7:0] host_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48; // 'H'
            3'd1:    c = 8'h6F; // 'o'
            3'd2:    c = 8'h73; // 's'
            3'd3:    c = 8'h74; // 't'
            3'd4:    c = 8'h3A; // ':'
            3'd5:    c = 8'h20; // ' '
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> sv/hrp_if.sv
// ============================================================================
// hrp_in_if / hrp_out_if
// Valid/ready channels for request bytes and per-byte parse results.
// ============================================================================
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] in_byte;

    modport source (output valid, output op, output in_byte, input ready);
    modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface hrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [11:0] out_pos;
    logic        out_is_host;
    logic [11:0] path_bytes;
    logic [11:0] host_bytes;

    modport source (output valid, output status, output byte_valid, output out_byte,
                    output out_pos, output out_is_host, output path_bytes,
                    output host_bytes, input ready);
    modport sink   (input valid, input status, input byte_valid, input out_byte,
                    input out_pos, input out_is_host, input path_bytes,
                    input host_bytes, output ready);
endinterface

>>> sv/hrp_front.sv
// ============================================================================
// hrp_front
// Accepts request bytes and classifies them for the back part.
// ============================================================================
module hrp_front (
    hrp_in_if.sink             in_ch,
    input  logic               q_full,
    output logic               push,
    output hrp_pkg::hrp_item_t item
);
    import hrp_pkg::*;

    // A transfer is taken whenever the queue has room.
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        item.restart  = in_ch.op;
        item.ch       = in_ch.in_byte;
        item.is_sp    = (in_ch.in_byte == CH_SP);
        item.is_slash = (in_ch.in_byte == CH_SLASH);
        item.is_cr    = (in_ch.in_byte == CH_CR);
        item.is_lf    = (in_ch.in_byte == CH_LF);
        item.is_nul   = (in_ch.in_byte == CH_NUL);
    end

endmodule

>>> sv/hrp_queue.sv
// ============================================================================
// hrp_queue
// Short FIFO of classified bytes between the front and back parts.
// ============================================================================
module hrp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hrp_pkg::hrp_item_t push_item,
    input  logic               pop,
    output logic               q_valid,
    output logic               q_full,
    output hrp_pkg::hrp_item_t q_item
);
    import hrp_pkg::*;

    hrp_item_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/hrp_back.sv
// ============================================================================
// hrp_back
// Parse state machine: takes classified bytes from the queue and produces one
// registered result per byte.
// ============================================================================
module hrp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [hrp_pkg::LEN_W-1:0]   buf_len,
    input  logic                        q_valid,
    input  hrp_pkg::hrp_item_t          q_item,
    output logic                        pop,
    hrp_out_if.source                   out_ch
);
    import hrp_pkg::*;

    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_PATH   = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_LF     = 3'd3;
    localparam logic [2:0] PH_NAME   = 3'd4;
    localparam logic [2:0] PH_HOST   = 3'd5;

    logic [2:0]        phase_reg, phase_next;
    logic [2:0]        match_reg, match_next;
    logic [CNT_W-1:0]  path_cnt_reg, path_cnt_next;
    logic [CNT_W-1:0]  host_cnt_reg, host_cnt_next;
    logic [1:0]        fstat_reg, fstat_next;

    logic              ovalid_reg;
    logic              obv_reg, obv_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic [CNT_W-1:0]  opos_reg, opos_next;
    logic              ohost_reg, ohost_next;

    logic [LEN_W-1:0]  len;
    logic [SUM_W-1:0]  path_sum;
    logic [SUM_W-1:0]  total_sum;
    logic [SUM_W-1:0]  host_pos;

    // The back part advances whenever its output register is free or drained.
    assign pop = q_valid && (!ovalid_reg || out_ch.ready);

    assign len       = (buf_len > LEN_W'(MAX_BUF)) ? LEN_W'(MAX_BUF) : buf_len;
    assign path_sum  = SUM_W'(path_cnt_reg) + SUM_W'(2);
    assign total_sum = SUM_W'(path_cnt_reg) + SUM_W'(host_cnt_reg) + SUM_W'(2);
    assign host_pos  = SUM_W'(path_cnt_reg) + SUM_W'(host_cnt_reg) + SUM_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        match_next    = match_reg;
        path_cnt_next = path_cnt_reg;
        host_cnt_next = host_cnt_reg;
        fstat_next    = fstat_reg;
        obv_next      = 1'b0;
        obyte_next    = '0;
        opos_next     = '0;
        ohost_next    = 1'b0;

        if (q_item.restart)
        begin
            phase_next    = PH_METHOD;
            match_next    = '0;
            path_cnt_next = '0;
            host_cnt_next = '0;
            fstat_next    = ST_MORE;
        end
        else if (fstat_reg == ST_MORE)
        begin
            case (phase_reg)
                PH_METHOD:
                begin
                    if (q_item.is_sp)
                    begin
                        phase_next = PH_PATH;
                    end
                end
                PH_PATH:
                begin
                    if (q_item.is_nul)
                    begin
                        fstat_next = ST_BAD;
                    end
                    else if (q_item.is_sp)
                    begin
                        if (path_cnt_reg == '0)
                        begin
                            fstat_next = ST_BAD;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else if (path_cnt_reg == '0 && !q_item.is_slash)
                    begin
                        fstat_next = ST_BAD;
                    end
                    else if (path_sum >= SUM_W'(len))
                    begin
                        fstat_next = ST_SMALL;
                    end
                    else
                    begin
                        obv_next      = 1'b1;
                        obyte_next    = q_item.ch;
                        opos_next     = path_cnt_reg;
                        path_cnt_next = path_cnt_reg + 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    if (q_item.is_cr)
                    begin
                        phase_next = PH_LF;
                    end
                end
                PH_LF:
                begin
                    if (!q_item.is_lf)
                    begin
                        fstat_next = ST_BAD;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                        match_next = '0;
                    end
                end
                PH_NAME:
                begin
                    // A mismatching byte is consumed and the line is skipped.
                    if (match_reg < NAME_LEN && q_item.ch == host_char(match_reg))
                    begin
                        match_next = match_reg + 1'b1;
                        if (match_reg + 1'b1 == NAME_LEN)
                        begin
                            phase_next = PH_HOST;
                        end
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_HOST:
                begin
                    if (q_item.is_cr)
                    begin
                        fstat_next = (host_cnt_reg == '0) ? ST_BAD : ST_DONE;
                    end
                    else if (total_sum > SUM_W'(len))
                    begin
                        fstat_next = ST_SMALL;
                    end
                    else
                    begin
                        obv_next      = 1'b1;
                        obyte_next    = q_item.ch;
                        ohost_next    = 1'b1;
                        opos_next     = host_pos[CNT_W-1:0];
                        host_cnt_next = host_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_METHOD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_METHOD;
            match_reg    <= '0;
            path_cnt_reg <= '0;
            host_cnt_reg <= '0;
            fstat_reg    <= ST_MORE;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                match_reg    <= match_next;
                path_cnt_reg <= path_cnt_next;
                host_cnt_reg <= host_cnt_next;
                fstat_reg    <= fstat_next;
                ovalid_reg   <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            obv_reg   <= obv_next;
            obyte_reg <= obyte_next;
            opos_reg  <= opos_next;
            ohost_reg <= ohost_next;
        end
    end

    assign out_ch.valid       = ovalid_reg;
    assign out_ch.status      = fstat_reg;
    assign out_ch.byte_valid  = obv_reg;
    assign out_ch.out_byte    = obyte_reg;
    assign out_ch.out_pos     = opos_reg;
    assign out_ch.out_is_host = ohost_reg;
    assign out_ch.path_bytes  = path_cnt_reg;
    assign out_ch.host_bytes  = host_cnt_reg;

    // A captured byte is only reported while the parse still needs data.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && obv_reg |-> fstat_reg == ST_MORE)
        else $error("captured byte reported with a final status");

    // A sticky status freezes the counts until a restart.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !q_item.restart && fstat_reg != ST_MORE
        |=> $stable(path_cnt_reg) && $stable(host_cnt_reg) && $stable(fstat_reg))
        else $error("state changed while status was sticky");

    // A restart always reports needs-more with empty counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.restart
        |=> fstat_reg == ST_MORE && path_cnt_reg == '0 && host_cnt_reg == '0 && !obv_reg)
        else $error("restart did not clear the parse state");

    // Host bytes are never captured before the path has been captured.
    assert property (@(posedge clk) disable iff (!rst_n)
        host_cnt_reg != '0 |-> path_cnt_reg != '0)
        else $error("host captured with an empty path");

endmodule

>>> sv/http_request_path_host_parser.sv
// ============================================================================
// http_request_path_host_parser
// Byte-serial HTTP request parser that extracts the request path and the
// Host header value and reports each captured byte at its buffer position.
// ============================================================================
// The block takes one request byte per transfer on in_ch and returns exactly
// one result per byte on out_ch, in order, at a sustained rate of one byte
// per clock cycle while out_ch is not stalled. A transferred byte is written
// into the queue, then popped into the result register that drives out_ch.
// The rate is set by the parse state machine in the back part, which
// updates its small state once per byte. A four-entry queue sits between
// the front part (handshake and byte classification) and the back part, so
// a stall on out_ch does not immediately stop input transfers, and the
// registered result can wait while new bytes keep arriving. An op of 1
// restarts parsing for a new request and returns a needs-more status. Once
// the status becomes complete, bad data or buffer too small, it stays there
// and further bytes produce no captured data until a restart. The buf_len
// register (byte address 0) sets the field buffer size; values above 4096
// act as 4096, and it should only be written while no transfer is in flight.
// ============================================================================
module http_request_path_host_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    hrp_in_if.sink                       in_ch,
    hrp_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hrp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import hrp_pkg::*;

    logic [LEN_W-1:0] buf_len_reg;
    logic             cfg_sel;
    hrp_item_t        front_item;
    hrp_item_t        q_item;
    logic             push;
    logic             pop;
    logic             q_valid;
    logic             q_full;

    // The only register lives at word index zero; bit 2 selects the word.
    assign cfg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? {{(32 - LEN_W){1'b0}}, buf_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_len_reg <= BUF_LEN_RESET;
        end
        else if (psel && penable && pwrite && cfg_sel)
        begin
            buf_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Front part: accepts transfers and classifies the byte.
    hrp_front u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .item   (front_item)
    );

    // Queue that decouples the front part from the parse state machine.
    hrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_item    (q_item)
    );

    // Back part: the parse state machine and the result register.
    hrp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .buf_len (buf_len_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

>>> test/tb_http_request_path_host_parser.sv
// ============================================================================
// tb_http_request_path_host_parser
// Self-checking testbench for the byte-serial HTTP path and Host parser.
// ============================================================================
// Request bytes go in over a valid/ready channel. Every accepted byte is run
// through a parse model kept in this file, and its predicted result is
// queued. Each result transfer from the block is checked field by field
// against the oldest prediction. A short directed sequence opens the run.
// Randomized requests follow, phase by phase over a range of buffer sizes,
// with random idle cycles on both sides and one long output stall.
// ============================================================================
module tb_http_request_path_host_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;

    // Byte address of the buffer size register.
    localparam logic [ADDR_W-1:0] REG_BUF_LEN = ADDR_W'(0);

    // The header name that opens the Host line, first character in the top byte.
    localparam logic [47:0] HOST_HEADER = "Host: ";

    // Test plan: one phase per buffer size. The random byte budget and the
    // idle percentages of the sender and the receiver are set per phase.
    // The last phase has no idle cycles at all.
    localparam int PLAN_N = 8;
    localparam int PLAN_BUF [PLAN_N]   = '{2, 3, 5, 16, 0, 40, 8191, 24};
    localparam int PLAN_ITEMS [PLAN_N] = '{20, 20, 30, 40, 10, 50, 40, 60};
    localparam int SEND_IDLE [PLAN_N]  = '{15, 0, 0, 30, 10, 15, 5, 0};
    localparam int SINK_IDLE [PLAN_N]  = '{15, 20, 0, 30, 10, 15, 5, 0};
    localparam int HOLD_PHASE = 2;
    localparam int HOLD_CYCLES = 150;

    typedef enum logic [2:0] {
        P_METHOD,
        P_PATH,
        P_SKIP,
        P_LF,
        P_NAME,
        P_HOST
    } parse_phase_e;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } req_byte_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic [11:0] out_pos;
        logic        out_is_host;
        logic [11:0] path_bytes;
        logic [11:0] host_bytes;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hrp_in_if  in_if ();
    hrp_out_if out_if ();

    // Everything the testbench drives has a known value from time zero.
    logic        in_valid = 1'b0;
    logic        in_op = 1'b0;
    logic [7:0]  in_data = 8'h00;
    logic        out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    assign in_if.valid   = in_valid;
    assign in_if.op      = in_op;
    assign in_if.in_byte = in_data;
    assign out_if.ready  = out_ready;

    http_request_path_host_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // Bytes waiting to be offered, and results predicted but not yet seen.
    req_byte_t     request_bytes [$];
    parse_result_t expected_results [$];

    int bytes_queued = 0;
    int bytes_taken = 0;
    int error_count = 0;

    // Flow control knobs shared by the stimulus and the two channel processes.
    int send_idle_pct = 0;
    int send_gap = 0;
    int sink_idle_pct = 0;
    int sink_stall = 0;
    int sink_hold = 0;
    bit sink_hold_req = 1'b0;

    // Set at a rising edge when the byte on offer was taken in that transfer.
    logic in_taken = 1'b0;

    // ------------------------------------------------------------------------
    // Parse model. It keeps its own copy of the register and the parse state
    // and is stepped once per accepted input transfer, in order.
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0] model_buf_len = BUF_LEN_RESET;
    parse_phase_e     model_phase = P_METHOD;
    int               model_match = 0;
    int               model_path = 0;
    int               model_host = 0;
    logic [1:0]       model_status = ST_MORE;

    function automatic void model_restart();
        model_phase  = P_METHOD;
        model_match  = 0;
        model_path   = 0;
        model_host   = 0;
        model_status = ST_MORE;
    endfunction

    function automatic parse_result_t parse_byte(input logic op, input logic [7:0] ch);
        parse_result_t r;
        int len;
        r = '0;
        // Sizes beyond the largest buffer act as the largest buffer.
        len = (model_buf_len > MAX_BUF) ? MAX_BUF : int'(model_buf_len);
        if (op)
            model_restart();
        else if (model_status == ST_MORE)
        begin
            case (model_phase)
                P_METHOD:
                    if (ch == CH_SP)
                        model_phase = P_PATH;
                P_PATH:
                begin
                    if (ch == CH_NUL)
                        model_status = ST_BAD;
                    else if (ch == CH_SP)
                    begin
                        // A space with nothing captured means an empty path.
                        if (model_path == 0)
                            model_status = ST_BAD;
                        else
                            model_phase = P_SKIP;
                    end
                    else if (model_path == 0 && ch != CH_SLASH)
                        model_status = ST_BAD;
                    else if (model_path + 2 >= len)
                        // Room must remain for the terminator and one host byte.
                        model_status = ST_SMALL;
                    else
                    begin
                        r.byte_valid = 1'b1;
                        r.out_byte   = ch;
                        r.out_pos    = model_path[11:0];
                        model_path++;
                    end
                end
                P_SKIP:
                    if (ch == CH_CR)
                        model_phase = P_LF;
                P_LF:
                begin
                    if (ch != CH_LF)
                        model_status = ST_BAD;
                    else
                    begin
                        model_phase = P_NAME;
                        model_match = 0;
                    end
                end
                P_NAME:
                begin
                    // The byte that breaks the match is consumed, even a CR.
                    if (model_match < 6 && ch == HOST_HEADER[47 - 8 * model_match -: 8])
                    begin
                        model_match++;
                        if (model_match == 6)
                            model_phase = P_HOST;
                    end
                    else
                        model_phase = P_SKIP;
                end
                P_HOST:
                begin
                    if (ch == CH_CR)
                        model_status = (model_host == 0) ? ST_BAD : ST_DONE;
                    else if (model_path + model_host + 2 > len)
                        model_status = ST_SMALL;
                    else
                    begin
                        // Host bytes land after the path and its terminator.
                        r.byte_valid  = 1'b1;
                        r.out_byte    = ch;
                        r.out_is_host = 1'b1;
                        r.out_pos     = 12'(model_path + 1 + model_host);
                        model_host++;
                    end
                end
                default:
                    model_phase = P_METHOD;
            endcase
        end
        r.status     = model_status;
        r.path_bytes = model_path[11:0];
        r.host_bytes = model_host[11:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. A byte stays on the channel until its transfer; idle
    // bursts are only started between bytes.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        req_byte_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            in_valid <= 1'b1;
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap--;
        end
        else if (request_bytes.size() == 0)
            in_valid <= 1'b0;
        else if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            send_gap = $urandom_range(0, 16);
        end
        else
        begin
            nxt = request_bytes.pop_front();
            in_valid <= 1'b1;
            in_op    <= nxt.op;
            in_data  <= nxt.data;
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver. Random stall bursts, plus one long hold-off on request
    // that lets the block fill up and push back on its input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (sink_hold_req)
        begin
            sink_hold_req = 1'b0;
            sink_hold = HOLD_CYCLES;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold--;
        end
        else if (sink_stall > 0)
        begin
            out_ready <= 1'b0;
            sink_stall--;
        end
        else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct)
        begin
            out_ready <= 1'b0;
            sink_stall = $urandom_range(0, 16);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Checks each result transfer against the oldest prediction,
    // then predicts the result of any input transfer at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        parse_result_t want;
        in_taken <= rst_n && in_valid && in_if.ready;
        if (rst_n)
        begin
            if (out_if.valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with none expected, status %0d",
                             $time, out_if.status);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 16'(want.status), 16'(out_if.status));
                    check_field("byte_valid", 16'(want.byte_valid), 16'(out_if.byte_valid));
                    check_field("out_byte", 16'(want.out_byte), 16'(out_if.out_byte));
                    check_field("out_pos", 16'(want.out_pos), 16'(out_if.out_pos));
                    check_field("out_is_host", 16'(want.out_is_host),
                                16'(out_if.out_is_host));
                    check_field("path_bytes", 16'(want.path_bytes), 16'(out_if.path_bytes));
                    check_field("host_bytes", 16'(want.host_bytes), 16'(out_if.host_bytes));
                end
            end
            if (in_valid && in_if.ready)
            begin
                expected_results.push_back(parse_byte(in_op, in_data));
                bytes_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic op, input logic [7:0] b);
        req_byte_t e;
        e.op = op;
        e.data = b;
        request_bytes.push_back(e);
        bytes_queued++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(1'b0, s[i]);
    endfunction

    // A path byte: mostly printable, sometimes any value but NUL and space.
    function automatic logic [7:0] path_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0)
            b = 8'($urandom_range(8'h21, 8'h7E));
        else
        begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_SP)
                b = 8'hA0;
        end
        return b;
    endfunction

    // Any byte but CR, for host values and for lines that get skipped.
    function automatic logic [7:0] non_cr_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1) != 0)
            b = 8'($urandom_range(8'h21, 8'h7E));
        else
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_CR)
                b = 8'h8D;
        end
        return b;
    endfunction

    // One randomized request. Most are well formed with random content; the
    // rest are broken in one way each, cut short by a restart, or plain noise.
    function automatic void push_request(input int max_len);
        int kind;
        int n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        push_byte(1'b1, 8'($urandom_range(0, 255)));
        if (kind >= 29 && kind < 37)
        begin
            n = $urandom_range(4, 20);
            repeat (n)
                push_byte(($urandom_range(0, 15) == 0), 8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(0, 6);
        repeat (n)
            push_byte(1'b0, 8'($urandom_range(8'h41, 8'h5A)));
        push_byte(1'b0, CH_SP);
        // Path: a wrong first byte, nothing at all, or a proper one.
        if (kind < 5)
        begin
            b = path_byte();
            push_byte(1'b0, (b == CH_SLASH) ? 8'h2E : b);
        end
        else if (kind >= 9)
            push_byte(1'b0, CH_SLASH);
        if (kind >= 5 && kind < 9)
            n = 0;
        else
            n = $urandom_range(0, max_len);
        repeat (n)
            push_byte(1'b0, path_byte());
        if (kind >= 9 && kind < 13)
            push_byte(1'b0, CH_NUL);
        push_byte(1'b0, CH_SP);
        if ($urandom_range(0, 1) != 0)
            push_text("HTTP/1.1");
        else
            repeat ($urandom_range(0, 8))
                push_byte(1'b0, non_cr_byte());
        push_byte(1'b0, CH_CR);
        if (kind >= 13 && kind < 17)
        begin
            b = 8'($urandom_range(0, 255));
            push_byte(1'b0, (b == CH_LF) ? 8'h4C : b);
        end
        else
            push_byte(1'b0, CH_LF);
        if (kind >= 17 && kind < 21)
        begin
            push_byte(1'b1, 8'($urandom_range(0, 255)));
            return;
        end
        // Other header lines, some of them close misses of the Host name.
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 4))
                0: push_text("Accept: */*");
                1: push_text("host: a");
                2:
                begin
                    // The CR breaks the match and is consumed, so the skipped
                    // line ends at the CR and LF pushed after it.
                    push_text("Hos");
                    push_byte(1'b0, CH_CR);
                end
                3: push_text("Host:x");
                default:
                    repeat ($urandom_range(0, 8))
                        push_byte(1'b0, non_cr_byte());
            endcase
            push_byte(1'b0, CH_CR);
            push_byte(1'b0, CH_LF);
        end
        if (kind >= 21 && kind < 25)
        begin
            push_text("Host: ");
            push_byte(1'b0, CH_CR);
        end
        else if (kind >= 37 || kind < 5 || (kind >= 9 && kind < 17))
        begin
            push_text("Host: ");
            repeat ($urandom_range(1, max_len))
                push_byte(1'b0, non_cr_byte());
            push_byte(1'b0, CH_CR);
        end
        // A few trailing bytes, mostly landing on a sticky status.
        repeat ($urandom_range(0, 2))
            push_byte(1'b0, 8'($urandom_range(0, 255)));
    endfunction

    // Wait until every queued byte was transferred and its result checked.
    task automatic wait_all_results();
        while (bytes_taken != bytes_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Write the buffer size over APB, then read it back.
    task automatic write_buf_len(input logic [LEN_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BUF_LEN;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model_buf_len = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[LEN_W-1:0] !== value)
        begin
            $display("%0t: buf_len read back mismatch, expected 0x%0h, actual 0x%0h",
                     $time, value, prdata[LEN_W-1:0]);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int goal;
        int max_len;
        model_restart();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset buffer size: a minimal complete request,
        // a byte after completion, then a wrong first path byte, an empty
        // path, and a NUL after an all-ones path byte, each after a restart.
        send_idle_pct = 10;
        sink_idle_pct = 10;
        push_text(" /");
        push_byte(1'b0, CH_SP);
        push_byte(1'b0, CH_CR);
        push_byte(1'b0, CH_LF);
        push_text("Host: h");
        push_byte(1'b0, CH_CR);
        push_byte(1'b0, 8'h41);
        push_byte(1'b1, 8'hFF);
        push_text(" X");
        push_byte(1'b1, 8'h00);
        push_byte(1'b0, CH_SP);
        push_byte(1'b0, CH_SP);
        push_byte(1'b1, 8'h00);
        push_text(" /");
        push_byte(1'b0, 8'hFF);
        push_byte(1'b0, CH_NUL);

        for (int p = 0; p < PLAN_N; p++)
        begin
            // The register is only written with the block fully drained.
            wait_all_results();
            repeat (4) @(negedge clk);
            write_buf_len(LEN_W'(PLAN_BUF[p]));
            send_idle_pct = SEND_IDLE[p];
            sink_idle_pct = SINK_IDLE[p];
            if (p == HOLD_PHASE)
                sink_hold_req = 1'b1;
            goal = bytes_queued + PLAN_ITEMS[p];
            max_len = (PLAN_BUF[p] < 22) ? PLAN_BUF[p] + 2 : 24;
            while (bytes_queued < goal)
            begin
                push_request(max_len);
                while (request_bytes.size() > 16)
                    @(negedge clk);
            end
        end

        wait_all_results();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("[http_request_path_host_parser] OK");
        else
            $display("[http_request_path_host_parser] ERROR");
        $finish;
    end

    // Hard stop in case the block hangs or drops results.
    initial
    begin
        #40_000_000;
        $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
        $display("[http_request_path_host_parser] ERROR");
        $finish;
    end

endmodule
